// File: rtl/core/asfm_pkg.sv
// ----------------------------------------------------------------------------
// asfm_pkg
// Shared widths, command and status codes, sequencer state and control
// structs for the filtered-mean array store.
// ----------------------------------------------------------------------------
`default_nettype none

package asfm_pkg;

  localparam int CMD_W   = 2;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;
  localparam int MEAN_W  = 40;
  localparam int FRAC_W  = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MEAN   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_DONE
  } state_t;

  // events seen by the sequencer
  typedef struct packed {
    logic accept;
    logic go_walk;
    logic go_div;
    logic walk_done;
    logic div_done;
    logic out_free;
  } seq_evt_t;

  // controls driven by the sequencer
  typedef struct packed {
    logic in_ready;
    logic walking;
    logic start_div;
    logic load_out;
  } seq_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/asfm_seq.sv
// ----------------------------------------------------------------------------
// asfm_seq
// Command sequencer: idle, compaction walk, divide, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module asfm_seq
  import asfm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire seq_evt_t evt,
  output seq_ctl_t      ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (evt.accept) begin
          priority if (evt.go_walk) begin
            state_next = S_WALK;
          end else if (evt.go_div) begin
            state_next = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (evt.walk_done) begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (evt.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (evt.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.in_ready  = (state == S_IDLE);
    ctl.walking   = (state == S_WALK);
    ctl.start_div = (state == S_IDLE) && evt.accept && evt.go_div && !evt.go_walk;
    ctl.load_out  = (state == S_DONE) && evt.out_free;
  end

endmodule

`default_nettype wire

// File: rtl/core/asfm_div.sv
// ----------------------------------------------------------------------------
// asfm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asfm_div #(
  parameter int DVD_W = 51,
  parameter int DSR_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // dividend register shifts out its top bit and takes in quotient bits
  assign trial    = {rem, dvd[DVD_W-1]};
  assign ge       = (trial >= {1'b0, dsr});
  assign diff     = trial - {1'b0, dsr};
  assign done     = busy && (cnt == CW'(1));
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DVD_W);
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= !done;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], ge};
      rem <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/array_store_filter_mean_core.sv
// ----------------------------------------------------------------------------
// array_store_filter_mean_core
// Packed store of signed words with fill count, running sum, in-place
// remove-all compaction and a Q8 mean through a bit-serial divider.
// ----------------------------------------------------------------------------
// Sequence: insert, no-op, dropped insert and empty mean go straight to the done
//   state; remove-all runs the store walk first, mean runs the serial divider
//   first; the result then loads into the output register once it is free.
// Flow: one word in flight; in_ready returns as the result loads into the output
//   register, and a stalled output holds the sequencer in its done state.
// Reset clears fill count, sum and handshakes; store contents need no clearing.
`default_nettype none

module array_store_filter_mean_core
  import asfm_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         command,
  input  wire logic signed [VAL_W-1:0]  value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STAT_W-1:0]             status,
  output logic [COUNT_W-1:0]            count,
  output logic [COUNT_W-1:0]            removed,
  output logic signed [MEAN_W-1:0]      mean_q8
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = VAL_W + CNT_W;
  localparam int DVD_W = SUM_W + FRAC_W;

  seq_evt_t evt;
  seq_ctl_t ctl;

  logic signed [VAL_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]        fill;
  logic signed [SUM_W-1:0] sum;
  logic                    accept;
  logic                    full;

  // walk
  logic [CNT_W-1:0]        rd;
  logic [CNT_W-1:0]        wr;
  logic                    pend;
  logic signed [VAL_W-1:0] rdata;
  logic signed [VAL_W-1:0] key;
  logic signed [SUM_W-1:0] acc;
  logic                    issue;
  logic                    keep;

  // memory write port
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;

  // staged result
  logic [STAT_W-1:0]       res_status;
  logic [CNT_W-1:0]        res_removed;
  logic                    res_mean;
  logic                    neg;

  // divider
  logic [SUM_W-1:0]        mag;
  logic [DVD_W-1:0]        quotient;
  logic                    div_done;
  logic [MEAN_W-1:0]       q_mean;

  assign accept = in_valid && in_ready;
  assign full   = (fill == CNT_W'(CAPACITY));
  assign issue  = ctl.walking && (rd != fill);
  assign keep   = pend && (rdata != key);

  assign evt.accept    = accept;
  assign evt.go_walk   = (command == CMD_REMOVE);
  assign evt.go_div    = (command == CMD_MEAN) && (fill != '0);
  assign evt.walk_done = ctl.walking && (rd == fill) && !pend;
  assign evt.div_done  = div_done;
  assign evt.out_free  = !out_valid || out_ready;

  assign in_ready = ctl.in_ready;

  asfm_seq u_seq (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .ctl (ctl)
  );

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  asfm_div #(
    .DVD_W (DVD_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.start_div),
    .dividend ({mag, FRAC_W'(0)}),
    .divisor  (fill),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_mean = quotient[MEAN_W-1:0];

  // single write port: append on insert, compacting write during the walk
  always_comb begin
    we    = 1'b0;
    waddr = fill[AW-1:0];
    wdata = value;
    if (ctl.walking) begin
      we    = keep;
      waddr = wr[AW-1:0];
      wdata = rdata;
    end else if (accept && (command == CMD_INSERT) && !full) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[rd[AW-1:0]];
    end
  end

  // store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= issue;
      if (accept && (command == CMD_INSERT) && !full) begin
        fill <= fill + CNT_W'(1);
        sum  <= sum + SUM_W'(value);
      end else if (evt.walk_done) begin
        fill <= wr;
        sum  <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd  <= '0;
      wr  <= '0;
      acc <= '0;
      key <= value;
    end else if (ctl.walking) begin
      if (issue) begin
        rd <= rd + CNT_W'(1);
      end
      if (keep) begin
        wr  <= wr + CNT_W'(1);
        acc <= acc + SUM_W'(rdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status  <= STAT_OK;
      res_removed <= '0;
      res_mean    <= evt.go_div && !evt.go_walk;
      neg         <= sum[SUM_W-1];
      if ((command == CMD_INSERT) && full) begin
        res_status <= STAT_FULL;
      end else if ((command == CMD_MEAN) && (fill == '0)) begin
        res_status <= STAT_EMPTY;
      end
    end else if (evt.walk_done) begin
      res_removed <= fill - wr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status  <= res_status;
      count   <= COUNT_W'(fill);
      removed <= COUNT_W'(res_removed);
      if (!res_mean) begin
        mean_q8 <= '0;
      end else if (neg) begin
        mean_q8 <= -q_mean;
      end else begin
        mean_q8 <= q_mean;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/asfm_check.sv
// ----------------------------------------------------------------------------
// asfm_check
// Port-level checks on the result word, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module asfm_check
  import asfm_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [STAT_W-1:0]       status,
  input wire logic [COUNT_W-1:0]      count,
  input wire logic [COUNT_W-1:0]      removed,
  input wire logic signed [MEAN_W-1:0] mean_q8
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
      && $stable(removed) && $stable(mean_q8))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_EMPTY) |-> (count == '0) && (mean_q8 == '0)
      && (removed == '0))
    else $error("empty status with nonzero count or mean");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FULL) |-> (removed == '0) && (mean_q8 == '0))
    else $error("dropped insert reports removal or mean");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (removed != '0) |-> (status == STAT_OK) && (mean_q8 == '0))
    else $error("remove-all word carries bad status or mean");

endmodule

bind array_store_filter_mean_core asfm_check u_asfm_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .count     (count),
  .removed   (removed),
  .mean_q8   (mean_q8)
);

`default_nettype wire

// File: tb/array_store_filter_mean_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_store_filter_mean_core_tb
// Drives command words through the input handshake and checks every result
// word, field by field, against the directed table or a queue-based mirror of
// the store. A short table of directed words runs first, then random traffic
// over a small value pool with random and occasional extreme values.
// ----------------------------------------------------------------------------

module array_store_filter_mean_core_tb;
  import asfm_pkg::*;

  localparam int CAPACITY     = 1024;
  localparam int RANDOM_WORDS = 450;
  localparam int STALL_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 64;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
    logic [COUNT_W-1:0]       removed;
    logic signed [MEAN_W-1:0] mean_q8;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] val;
    bit                      typed;
    result_t                 res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] command = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] removed;
  logic signed [MEAN_W-1:0] mean_q8;

  // mirror of the store contents and its running sum
  logic signed [VAL_W-1:0] mirror_elems[$];
  longint mirror_sum = 0;

  result_t due_results[$];
  stim_row_t dir_rows[$];
  logic signed [VAL_W-1:0] pool [8];
  bit steady = 1'b0;
  int fail_count = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  array_store_filter_mean_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .count(count),
    .removed(removed),
    .mean_q8(mean_q8)
  );

  function automatic result_t store_update(input logic [CMD_W-1:0] cmd,
                                           input logic signed [VAL_W-1:0] val);
    result_t r;
    logic signed [VAL_W-1:0] kept[$];
    longint total;
    longint q;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (mirror_elems.size() < CAPACITY) begin
          mirror_elems.push_back(val);
          mirror_sum += val;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        total = 0;
        foreach (mirror_elems[i]) begin
          if (mirror_elems[i] != val) begin
            kept.push_back(mirror_elems[i]);
            total += mirror_elems[i];
          end
        end
        r.removed = COUNT_W'(mirror_elems.size() - kept.size());
        mirror_elems = kept;
        mirror_sum = total;
      end
      CMD_MEAN: begin
        if (mirror_elems.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // longint division truncates toward zero
          q = (mirror_sum * 256) / longint'(mirror_elems.size());
          r.mean_q8 = q[MEAN_W-1:0];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(mirror_elems.size());
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return pool[$urandom_range(0, 7)];
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // one word through the input handshake; expectation queued as it is offered
  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic signed [VAL_W-1:0] val,
                           input bit typed = 1'b0,
                           input result_t typed_res = '0);
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= val;
    r = store_update(cmd, val);
    due_results.push_back(typed ? typed_res : r);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                         input bit typed = 1'b0, input logic [STAT_W-1:0] st = STAT_OK,
                         input int cnt = 0, input int rem = 0,
                         input logic signed [MEAN_W-1:0] mean = '0);
    stim_row_t row;
    row.cmd = cmd;
    row.val = val;
    row.typed = typed;
    row.res.status = st;
    row.res.count = COUNT_W'(cnt);
    row.res.removed = COUNT_W'(rem);
    row.res.mean_q8 = mean;
    dir_rows.push_back(row);
  endtask

  // result side: ready held for a while, then dropped for a random gap
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result word with none expected: status %0d count %0d", status, count);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          fail_count++;
        end
        if (removed !== want.removed) begin
          $error("removed: expected %0d, got %0d", want.removed, removed);
          fail_count++;
        end
        if (mean_q8 !== want.mean_q8) begin
          $error("mean_q8: expected %0d, got %0d", want.mean_q8, mean_q8);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic signed [VAL_W-1:0] val;

    foreach (pool[k]) pool[k] = $urandom;

    add_row(CMD_MEAN, 32'sd0, 1'b1, STAT_EMPTY, 0, 0, '0);
    add_row(CMD_REMOVE, 32'sd5, 1'b1, STAT_OK, 0, 0, '0);
    add_row(CMD_NOP, -32'sd1, 1'b1, STAT_OK, 0, 0, '0);
    add_row(CMD_INSERT, INT_MAX, 1'b1, STAT_OK, 1, 0, '0);
    add_row(CMD_MEAN, 32'sd0, 1'b1, STAT_OK, 1, 0, 40'sh7F_FFFF_FF00);
    add_row(CMD_INSERT, INT_MIN, 1'b1, STAT_OK, 2, 0, '0);
    add_row(CMD_MEAN, INT_MIN, 1'b1, STAT_OK, 2, 0, -40'sd128);
    add_row(CMD_INSERT, 32'sd0, 1'b1, STAT_OK, 3, 0, '0);
    add_row(CMD_INSERT, -32'sd1, 1'b1, STAT_OK, 4, 0, '0);
    add_row(CMD_INSERT, -32'sd1, 1'b1, STAT_OK, 5, 0, '0);
    add_row(CMD_MEAN, INT_MAX);   // negative, not exact: truncation toward zero
    add_row(CMD_INSERT, 32'sd7, 1'b1, STAT_OK, 6, 0, '0);
    add_row(CMD_REMOVE, -32'sd1, 1'b1, STAT_OK, 4, 2, '0);
    add_row(CMD_REMOVE, 32'sd12345, 1'b1, STAT_OK, 4, 0, '0);
    add_row(CMD_NOP, 32'sh5A5A_5A5A, 1'b1, STAT_OK, 4, 0, '0);
    add_row(CMD_MEAN, 32'sd0);
    add_row(CMD_INSERT, 32'sd3, 1'b1, STAT_OK, 5, 0, '0);
    add_row(CMD_REMOVE, INT_MAX, 1'b1, STAT_OK, 4, 1, '0);
    add_row(CMD_MEAN, -32'sd1);
    add_row(CMD_REMOVE, INT_MIN, 1'b1, STAT_OK, 3, 1, '0);
    add_row(CMD_REMOVE, 32'sd0, 1'b1, STAT_OK, 2, 1, '0);
    add_row(CMD_REMOVE, 32'sd7, 1'b1, STAT_OK, 1, 1, '0);
    add_row(CMD_REMOVE, 32'sd3, 1'b1, STAT_OK, 0, 1, '0);
    add_row(CMD_MEAN, 32'sd0, 1'b1, STAT_EMPTY, 0, 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        foreach (pool[k]) pool[k] = $urandom;
      end
      case ($urandom_range(0, 99)) inside
        [0:54]:  cmd = CMD_INSERT;
        [55:74]: cmd = CMD_REMOVE;
        [75:94]: cmd = CMD_MEAN;
        default: cmd = CMD_NOP;
      endcase
      // keep walks short
      if (mirror_elems.size() > 256) cmd = CMD_REMOVE;
      val = pick_value();
      if (cmd == CMD_REMOVE && mirror_elems.size() > 0 && $urandom_range(0, 1) == 0)
        val = mirror_elems[$urandom_range(0, mirror_elems.size() - 1)];
      send_word(cmd, val);
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/asfm_pkg.sv
rtl/core/asfm_seq.sv
rtl/core/asfm_div.sv
rtl/core/array_store_filter_mean_core.sv
rtl/core/asfm_check.sv
tb/array_store_filter_mean_core_tb.sv
